// File: sv/spsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsq_pkg
// Shared codes, widths, types and the coil phase table of the stepper phase
// sequencer.
// ----------------------------------------------------------------------------
package spsq_pkg;

   localparam int CFG_W       = 16;
   localparam int AMOUNT_W    = 16;
   localparam int PRODUCT_W   = 32;
   localparam int SEQ_W       = 24;
   localparam int PHASE_W     = 3;
   localparam int COILS_W     = 4;
   localparam int CSR_INDEX_W = 1;

   localparam logic REQ_TICK    = 1'b0;
   localparam logic REQ_COMMAND = 1'b1;

   localparam logic [1:0] MODE_BIPOLAR_FULL  = 2'd0;
   localparam logic [1:0] MODE_UNIPOLAR_FULL = 2'd1;
   localparam logic [1:0] MODE_UNIPOLAR_HALF = 2'd2;

   localparam logic [1:0] KIND_ONE_SEQ = 2'd0;
   localparam logic [1:0] KIND_DEGREES = 2'd1;
   localparam logic [1:0] KIND_TURNS   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS_PER_TURN = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_DELAY    = 1'b1;

   localparam logic [CFG_W-1:0] STEPS_PER_TURN_RESET = 16'd500;
   localparam logic [CFG_W-1:0] PHASE_DELAY_RESET    = 16'd2;

   localparam logic [AMOUNT_W-1:0] MAX_TURNS = 16'd255;

   // degrees: floor(p / 360) = floor((p >> 3) / 45), reciprocal multiply
   localparam longint DEG_PER_TURN = 360;
   localparam int     DEG_SHIFT    = 3;
   localparam longint DEG_ODD      = DEG_PER_TURN >> DEG_SHIFT;
   localparam int     DEG_X_W      = 22;
   localparam int     RECIP_SHIFT  = 28;
   localparam longint RECIP_VAL    = ((64'd1 << RECIP_SHIFT) + DEG_ODD - 1) / DEG_ODD;
   localparam int     RECIP_W      = 23;
   localparam int     DEG_QM_W     = DEG_X_W + RECIP_W;
   localparam logic [RECIP_W-1:0]   RECIP_45 = RECIP_VAL[RECIP_W-1:0];
   localparam longint SAT_VAL      = 65536 * DEG_PER_TURN;
   localparam logic [PRODUCT_W-1:0] DEG_SAT_PRODUCT = SAT_VAL[PRODUCT_W-1:0];

   typedef struct packed {
      logic               req_type;
      logic               direction;
      logic [1:0]         drive_mode;
      logic [SEQ_W-1:0]   seq_count;
   } spsq_cmd_type;

   function automatic logic [COILS_W-1:0] pattern_at(input logic dir,
                                                    input logic [1:0] mode,
                                                    input logic [PHASE_W-1:0] idx);
      logic [COILS_W-1:0] pat;
      pat = '0;
      case (mode)
         MODE_BIPOLAR_FULL: begin
            case (idx[1:0])
               2'd0:    pat = dir ? 4'h8 : 4'h1;
               2'd1:    pat = dir ? 4'h2 : 4'h4;
               2'd2:    pat = dir ? 4'h4 : 4'h2;
               default: pat = dir ? 4'h1 : 4'h8;
            endcase
         end
         MODE_UNIPOLAR_FULL: begin
            case (idx[1:0])
               2'd0:    pat = 4'h1;
               2'd1:    pat = dir ? 4'h2 : 4'h4;
               2'd2:    pat = 4'h8;
               default: pat = dir ? 4'h4 : 4'h2;
            endcase
         end
         default: begin
            case (idx)
               3'd0:    pat = 4'h1;
               3'd1:    pat = dir ? 4'h3 : 4'h5;
               3'd2:    pat = dir ? 4'h2 : 4'h4;
               3'd3:    pat = dir ? 4'hA : 4'hC;
               3'd4:    pat = 4'h8;
               3'd5:    pat = dir ? 4'hC : 4'hA;
               3'd6:    pat = dir ? 4'h4 : 4'h2;
               default: pat = dir ? 4'h5 : 4'h3;
            endcase
         end
      endcase
      return pat;
   endfunction

endpackage

// File: sv/spsq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsq_req_if / spsq_rsp_if
// Valid/ready channels for command and tick beats in and result beats out.
// ----------------------------------------------------------------------------
interface spsq_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic        direction;
   logic [1:0]  drive_mode;
   logic [1:0]  amount_kind;
   logic [15:0] amount;

   modport source (output valid, req_type, direction, drive_mode, amount_kind, amount,
                   input ready);
   modport sink   (input valid, req_type, direction, drive_mode, amount_kind, amount,
                   output ready);
endinterface

interface spsq_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] coils;
   logic       busy_res;
   logic       done_res;
   logic       rejected;

   modport source (output valid, coils, busy_res, done_res, rejected, input ready);
   modport sink   (input valid, coils, busy_res, done_res, rejected, output ready);
endinterface

// File: sv/spsq_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsq_count
// Input register and the two stages that turn a command's amount into a
// count of full phase sequences.
// ----------------------------------------------------------------------------
module spsq_count
   import spsq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   spsq_req_if.sink           req_chan,
   input  logic [CFG_W-1:0]   steps_per_turn,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output spsq_cmd_type       cmd
);

   // stage one: registered beat
   logic                s1_valid_ff;
   logic                s1_req_type_ff;
   logic                s1_dir_ff;
   logic [1:0]          s1_mode_ff;
   logic [1:0]          s1_kind_ff;
   logic [AMOUNT_W-1:0] s1_amount_ff;
   logic                s1_ready;

   // stage two: product
   logic                 s2_valid_ff;
   logic                 s2_req_type_ff;
   logic                 s2_dir_ff;
   logic [1:0]           s2_mode_ff;
   logic [1:0]           s2_kind_ff;
   logic [PRODUCT_W-1:0] s2_prod_ff;
   logic [PRODUCT_W-1:0] s2_prod_in;
   logic [AMOUNT_W-1:0]  mult_amount;
   logic                 s2_ready;

   // stage three: sequence count
   logic                 s3_valid_ff;
   spsq_cmd_type         s3_cmd_ff;
   spsq_cmd_type         s3_cmd_in;
   logic                 s3_ready;
   logic [DEG_X_W-1:0]   deg_x;
   logic [DEG_QM_W-1:0]  deg_qm;
   logic [SEQ_W-1:0]     seq_count;

   assign s3_ready = !s3_valid_ff || cmd_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (s1_ready) begin
         s1_req_type_ff <= req_chan.req_type;
         s1_dir_ff      <= req_chan.direction;
         s1_mode_ff     <= req_chan.drive_mode;
         s1_kind_ff     <= req_chan.amount_kind;
         s1_amount_ff   <= req_chan.amount;
      end
   end

   // turn count saturates before the multiply
   always_comb begin
      mult_amount = s1_amount_ff;
      if (s1_kind_ff == KIND_TURNS && s1_amount_ff > MAX_TURNS) begin
         mult_amount = MAX_TURNS;
      end
   end

   assign s2_prod_in = PRODUCT_W'(mult_amount) * PRODUCT_W'(steps_per_turn);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready) begin
         s2_req_type_ff <= s1_req_type_ff;
         s2_dir_ff      <= s1_dir_ff;
         s2_mode_ff     <= s1_mode_ff;
         s2_kind_ff     <= s1_kind_ff;
         s2_prod_ff     <= s2_prod_in;
      end
   end

   // divide by 360 as a shift by 3 and a reciprocal multiply by 45
   assign deg_x  = s2_prod_ff[DEG_SHIFT +: DEG_X_W];
   assign deg_qm = DEG_QM_W'(deg_x) * DEG_QM_W'(RECIP_45);

   always_comb begin
      case (s2_kind_ff)
         KIND_DEGREES: begin
            if (s2_prod_ff >= DEG_SAT_PRODUCT) begin
               seq_count = SEQ_W'(16'hFFFF);
            end else begin
               seq_count = SEQ_W'(deg_qm[RECIP_SHIFT +: AMOUNT_W]);
            end
         end
         KIND_TURNS: seq_count = s2_prod_ff[SEQ_W-1:0];
         default:    seq_count = SEQ_W'(1);
      endcase
   end

   always_comb begin
      s3_cmd_in.req_type   = s2_req_type_ff;
      s3_cmd_in.direction  = s2_dir_ff;
      s3_cmd_in.drive_mode = s2_mode_ff;
      s3_cmd_in.seq_count  = seq_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_ready) begin
         s3_cmd_ff <= s3_cmd_in;
      end
   end

   assign cmd_valid = s3_valid_ff;
   assign cmd       = s3_cmd_ff;

endmodule

// File: sv/spsq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsq_core
// Motion state: phase, hold and sequence counters, coil pattern, and the
// result register.
// ----------------------------------------------------------------------------
module spsq_core
   import spsq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  spsq_cmd_type       cmd,
   input  logic [CFG_W-1:0]   phase_delay_ticks,
   spsq_rsp_if.source         rsp_chan
);

   logic [COILS_W-1:0] pattern_ff, pattern_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [CFG_W-1:0]   hold_ff, hold_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic               running_ff, running_in;
   logic               dir_ff, dir_in;
   logic [1:0]         mode_ff, mode_in;

   logic               rsp_valid_ff;
   logic [COILS_W-1:0] rsp_coils_ff;
   logic               rsp_busy_ff;
   logic               rsp_done_ff;
   logic               rsp_rej_ff;

   logic               fire;
   logic               done;
   logic               rej;
   logic [1:0]         cmd_mode;
   logic [CFG_W-1:0]   load_delay;
   logic [CFG_W-1:0]   hold_dec;
   logic [PHASE_W:0]   phase_next;
   logic [PHASE_W:0]   phases_per_seq;
   logic               wrap;
   logic [SEQ_W-1:0]   seq_dec;

   assign cmd_ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire      = cmd_valid && cmd_ready;

   assign cmd_mode   = (cmd.drive_mode > MODE_UNIPOLAR_HALF) ? MODE_UNIPOLAR_HALF
                                                              : cmd.drive_mode;
   assign load_delay = (phase_delay_ticks == '0) ? CFG_W'(1) : phase_delay_ticks;
   assign hold_dec   = (hold_ff != '0) ? hold_ff - CFG_W'(1) : hold_ff;
   assign phase_next = {1'b0, phase_ff} + (PHASE_W+1)'(1);
   assign phases_per_seq = (mode_ff >= MODE_UNIPOLAR_HALF) ? (PHASE_W+1)'(8)
                                                            : (PHASE_W+1)'(4);
   assign wrap    = phase_next >= phases_per_seq;
   assign seq_dec = (wrap && seq_ff != '0) ? seq_ff - SEQ_W'(1) : seq_ff;

   always_comb begin
      pattern_in = pattern_ff;
      phase_in   = phase_ff;
      hold_in    = hold_ff;
      seq_in     = seq_ff;
      running_in = running_ff;
      dir_in     = dir_ff;
      mode_in    = mode_ff;
      done       = 1'b0;
      rej        = 1'b0;
      if (fire) begin
         if (cmd.req_type == REQ_COMMAND) begin
            if (running_ff) begin
               rej = 1'b1;
            end else if (cmd.seq_count == '0) begin
               done = 1'b1;
            end else begin
               running_in = 1'b1;
               dir_in     = cmd.direction;
               mode_in    = cmd_mode;
               phase_in   = '0;
               seq_in     = cmd.seq_count;
               pattern_in = pattern_at(cmd.direction, cmd_mode, '0);
               hold_in    = load_delay;
            end
         end else if (running_ff) begin
            hold_in = hold_dec;
            if (hold_dec == '0) begin
               seq_in = seq_dec;
               if (wrap && seq_dec == '0) begin
                  running_in = 1'b0;
                  done       = 1'b1;
               end else begin
                  phase_in   = wrap ? '0 : phase_next[PHASE_W-1:0];
                  pattern_in = pattern_at(dir_ff, mode_ff,
                                          wrap ? '0 : phase_next[PHASE_W-1:0]);
                  hold_in    = load_delay;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         phase_ff   <= '0;
         hold_ff    <= '0;
         seq_ff     <= '0;
         running_ff <= 1'b0;
         dir_ff     <= 1'b0;
         mode_ff    <= '0;
      end else begin
         pattern_ff <= pattern_in;
         phase_ff   <= phase_in;
         hold_ff    <= hold_in;
         seq_ff     <= seq_in;
         running_ff <= running_in;
         dir_ff     <= dir_in;
         mode_ff    <= mode_in;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire) begin
         rsp_coils_ff <= pattern_in;
         rsp_busy_ff  <= running_in;
         rsp_done_ff  <= done;
         rsp_rej_ff   <= rej;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.coils    = rsp_coils_ff;
   assign rsp_chan.busy_res = rsp_busy_ff;
   assign rsp_chan.done_res = rsp_done_ff;
   assign rsp_chan.rejected = rsp_rej_ff;

endmodule

// File: sv/stepper_phase_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_phase_sequencer
// Stepper motor coil sequencer driven by motion commands and time ticks.
// ----------------------------------------------------------------------------
// One result beat comes out for every request beat, in order. The block takes
// a new beat in every cycle unless back-pressure stalls it; a result beat is
// valid once its request has passed the input register, the amount multiplier
// register and the sequence count register into the result register. The
// motion state is updated once per beat in the last stage, so a tick or
// command sees all earlier beats. Back-pressure on the result side stalls the
// stages in turn, and the earlier stages keep filling while they have room.
// The user must write registers through the csr_ port only while no beat is
// in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module stepper_phase_sequencer
   import spsq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   spsq_req_if.sink                req_chan,
   spsq_rsp_if.source              rsp_chan,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]        csr_wdata
);

   logic [CFG_W-1:0] steps_per_turn_ff;
   logic [CFG_W-1:0] phase_delay_ff;
   logic             cmd_valid;
   logic             cmd_ready;
   spsq_cmd_type     cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_per_turn_ff <= STEPS_PER_TURN_RESET;
         phase_delay_ff    <= PHASE_DELAY_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STEPS_PER_TURN: steps_per_turn_ff <= csr_wdata;
            CSR_PHASE_DELAY:    phase_delay_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   spsq_count u_count (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .steps_per_turn (steps_per_turn_ff),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd            (cmd)
   );

   spsq_core u_core (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd_ready         (cmd_ready),
      .cmd               (cmd),
      .phase_delay_ticks (phase_delay_ff),
      .rsp_chan          (rsp_chan)
   );

endmodule

// File: tb/tb_stepper_phase_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_phase_sequencer
// Self-checking bench for the stepper phase sequencer. Command and tick beats
// go in with random gaps and back-pressure. A scoreboard class tracks the
// motor state and the register settings, predicts the coil result of every
// accepted beat, and compares each result beat field by field. Directed moves
// cover empty commands, rejected commands, the reserved mode and amount
// codes and zero settings. Random moves follow under several register
// settings.
// ----------------------------------------------------------------------------
module tb_stepper_phase_sequencer;
   import spsq_pkg::*;

   localparam logic [1:0]  MODE_RESERVED    = 2'd3;
   localparam logic [1:0]  KIND_RESERVED    = 2'd3;
   localparam longint      DEGREES_PER_TURN = 360;
   localparam int unsigned SEQ_SATURATION   = 65535;

   // coil pattern per direction, drive mode and phase
   localparam logic [COILS_W-1:0] PHASE_COILS [2][3][8] = '{
      '{ '{4'h1, 4'h4, 4'h2, 4'h8, 4'h0, 4'h0, 4'h0, 4'h0},
         '{4'h1, 4'h4, 4'h8, 4'h2, 4'h0, 4'h0, 4'h0, 4'h0},
         '{4'h1, 4'h5, 4'h4, 4'hC, 4'h8, 4'hA, 4'h2, 4'h3} },
      '{ '{4'h8, 4'h2, 4'h4, 4'h1, 4'h0, 4'h0, 4'h0, 4'h0},
         '{4'h1, 4'h2, 4'h8, 4'h4, 4'h0, 4'h0, 4'h0, 4'h0},
         '{4'h1, 4'h3, 4'h2, 4'hA, 4'h8, 4'hC, 4'h4, 4'h5} }
   };

   typedef struct packed {
      logic               req_type;
      logic               direction;
      logic [1:0]         drive_mode;
      logic [1:0]         amount_kind;
      logic [AMOUNT_W-1:0] amount;
   } motion_req_type;

   typedef struct packed {
      logic [COILS_W-1:0] coils;
      logic               busy;
      logic               done;
      logic               rejected;
   } coil_result_type;

   class coil_scoreboard;
      logic [CFG_W-1:0]   cfg_steps;
      logic [CFG_W-1:0]   cfg_delay;
      logic [COILS_W-1:0] pattern;
      int unsigned        phase;
      int unsigned        hold_count;
      int unsigned        seq_remaining;
      bit                 moving;
      logic               dir_latched;
      logic [1:0]         mode_latched;
      coil_result_type    awaited[$];
      int                 errors;

      function new();
         cfg_steps     = STEPS_PER_TURN_RESET;
         cfg_delay     = PHASE_DELAY_RESET;
         pattern       = '0;
         phase         = 0;
         hold_count    = 0;
         seq_remaining = 0;
         moving        = 1'b0;
         dir_latched   = 1'b0;
         mode_latched  = MODE_BIPOLAR_FULL;
         errors        = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
         if (idx == CSR_STEPS_PER_TURN) begin
            cfg_steps = val;
         end else if (idx == CSR_PHASE_DELAY) begin
            cfg_delay = val;
         end
      endfunction

      function int unsigned hold_reload();
         return (cfg_delay == 0) ? 1 : int'(cfg_delay);
      endfunction

      function void note_beat(motion_req_type b);
         coil_result_type r;
         logic [1:0]      mode;
         longint unsigned product;
         int unsigned     turns;
         int unsigned     count;
         int unsigned     nxt;
         int unsigned     span;
         r = '0;
         mode = (b.drive_mode > MODE_UNIPOLAR_HALF) ? MODE_UNIPOLAR_HALF : b.drive_mode;
         if (b.req_type == REQ_COMMAND) begin
            if (moving) begin
               r.rejected = 1'b1;
            end else begin
               if (b.amount_kind == KIND_DEGREES) begin
                  product = (64'(b.amount) * 64'(cfg_steps)) / DEGREES_PER_TURN;
                  count = (product > SEQ_SATURATION) ? SEQ_SATURATION : 32'(product);
               end else if (b.amount_kind == KIND_TURNS) begin
                  turns = (b.amount > MAX_TURNS) ? MAX_TURNS : b.amount;
                  count = turns * cfg_steps;
               end else begin
                  count = 1;
               end
               if (count == 0) begin
                  r.done = 1'b1;
               end else begin
                  moving        = 1'b1;
                  dir_latched   = b.direction;
                  mode_latched  = mode;
                  phase         = 0;
                  seq_remaining = count;
                  pattern       = PHASE_COILS[b.direction][mode][0];
                  hold_count    = hold_reload();
               end
            end
         end else if (moving) begin
            if (hold_count != 0) hold_count--;
            if (hold_count == 0) begin
               span = (mode_latched == MODE_UNIPOLAR_HALF) ? 8 : 4;
               nxt = phase + 1;
               if (nxt >= span) begin
                  nxt = 0;
                  if (seq_remaining != 0) seq_remaining--;
               end
               if (nxt == 0 && seq_remaining == 0) begin
                  moving = 1'b0;
                  r.done = 1'b1;
               end else begin
                  phase      = nxt;
                  pattern    = PHASE_COILS[dir_latched][mode_latched][phase];
                  hold_count = hold_reload();
               end
            end
         end
         r.coils = pattern;
         r.busy  = moving;
         awaited.push_back(r);
      endfunction

      function void check_result(coil_result_type got);
         coil_result_type want;
         if (awaited.size() == 0) begin
            if (errors < 10)
               $display("unexpected result beat: coils %h busy %b done %b rejected %b",
                        got.coils, got.busy, got.done, got.rejected);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.coils !== want.coils || got.busy !== want.busy ||
             got.done !== want.done || got.rejected !== want.rejected) begin
            if (errors < 10)
               $display(
                  "mismatch exp/got: coils %h/%h busy %b/%b done %b/%b rejected %b/%b",
                  want.coils, got.coils, want.busy, got.busy,
                  want.done, got.done, want.rejected, got.rejected);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_wdata;
   bit                     quiet_traffic;
   int unsigned            beats_sent;
   coil_scoreboard         sb;

   spsq_req_if req_if();
   spsq_rsp_if rsp_if();

   stepper_phase_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

   task automatic send_beat(input motion_req_type b);
      int unsigned gap;
      gap = quiet_traffic ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.req_type    <= b.req_type;
      req_if.direction   <= b.direction;
      req_if.drive_mode  <= b.drive_mode;
      req_if.amount_kind <= b.amount_kind;
      req_if.amount      <= b.amount;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_beat(b);
      beats_sent++;
   endtask

   task automatic send_tick();
      motion_req_type b;
      b = motion_req_type'(22'($urandom));
      b.req_type = REQ_TICK;
      send_beat(b);
   endtask

   task automatic send_command(input logic dir, input logic [1:0] mode,
                               input logic [1:0] kind, input logic [AMOUNT_W-1:0] amt);
      motion_req_type b;
      b.req_type    = REQ_COMMAND;
      b.direction   = dir;
      b.drive_mode  = mode;
      b.amount_kind = kind;
      b.amount      = amt;
      send_beat(b);
   endtask

   // tick until the move ends, with the odd command thrown in while busy
   task automatic finish_motion();
      motion_req_type b;
      while (sb.moving) begin
         if ($urandom_range(0, 11) == 0) begin
            b = motion_req_type'(22'($urandom));
            b.req_type = REQ_COMMAND;
            send_beat(b);
         end else begin
            send_tick();
         end
      end
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.awaited.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_wr_en <= 1'b0;
   endtask

   // amounts kept to a few sequences so that moves stay short
   task automatic random_motion(input logic [CFG_W-1:0] steps);
      int unsigned         roll;
      int unsigned         deg_cap;
      int unsigned         turn_cap;
      logic [1:0]          kind;
      logic [AMOUNT_W-1:0] amt;
      deg_cap  = (steps == 0) ? 65535 : 1799 / steps;
      turn_cap = (steps == 0) ? 65535 : 4 / steps;
      roll = $urandom_range(0, 9);
      if (roll < 4) begin
         kind = KIND_ONE_SEQ;
         amt  = 16'($urandom);
      end else if (roll == 4) begin
         kind = KIND_RESERVED;
         amt  = 16'($urandom);
      end else if (roll < 8) begin
         kind = KIND_DEGREES;
         amt  = 16'($urandom_range(0, deg_cap));
      end else begin
         kind = KIND_TURNS;
         amt  = 16'($urandom_range(0, turn_cap));
      end
      send_command(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), kind, amt);
      finish_motion();
      repeat ($urandom_range(0, 2)) send_tick();
   endtask

   initial begin : result_sink
      int unsigned     stall;
      coil_result_type got;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = quiet_traffic ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         got.coils    = rsp_if.coils;
         got.busy     = rsp_if.busy_res;
         got.done     = rsp_if.done_res;
         got.rejected = rsp_if.rejected;
         sb.check_result(got);
      end
   end

   initial begin : stimulus
      logic [CFG_W-1:0] steps;
      int unsigned      phase_end;
      int unsigned      waited;
      sb = new();
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.req_type    = REQ_TICK;
      req_if.direction   = 1'b0;
      req_if.drive_mode  = MODE_BIPOLAR_FULL;
      req_if.amount_kind = KIND_ONE_SEQ;
      req_if.amount      = '0;
      quiet_traffic      = 1'b0;
      beats_sent         = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: idle tick, empty moves, one sequence by degrees, busy command
      send_tick();
      send_command(1'b0, MODE_BIPOLAR_FULL, KIND_DEGREES, 16'd0);
      send_command(1'b1, MODE_UNIPOLAR_HALF, KIND_TURNS, 16'd0);
      send_command(1'b0, MODE_BIPOLAR_FULL, KIND_DEGREES, 16'd1);
      send_tick();
      send_command(1'b1, MODE_UNIPOLAR_FULL, KIND_ONE_SEQ, 16'hFFFF);
      finish_motion();

      // zero settings and the reserved codes
      write_csr(CSR_STEPS_PER_TURN, 16'd0);
      write_csr(CSR_PHASE_DELAY, 16'd0);
      send_command(1'b0, MODE_BIPOLAR_FULL, KIND_DEGREES, 16'hFFFF);
      send_command(1'b1, MODE_UNIPOLAR_FULL, KIND_TURNS, 16'hFFFF);
      send_command(1'b1, MODE_RESERVED, KIND_RESERVED, 16'h0000);
      finish_motion();

      write_csr(CSR_STEPS_PER_TURN, 16'hFFFF);
      write_csr(CSR_PHASE_DELAY, 16'd1);
      send_command(1'b1, MODE_UNIPOLAR_FULL, KIND_ONE_SEQ, 16'h0000);
      finish_motion();
      write_csr(CSR_PHASE_DELAY, 16'hFFFF);
      send_tick();
      send_command(1'b0, MODE_BIPOLAR_FULL, KIND_DEGREES, 16'd0);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       steps = 16'd1;
            1:       steps = 16'd2;
            2:       steps = 16'd0;
            3:       steps = 16'($urandom_range(1, 4));
            4:       steps = 16'hFFFF;
            default: steps = 16'd3;
         endcase
         write_csr(CSR_STEPS_PER_TURN, steps);
         write_csr(CSR_PHASE_DELAY, 16'($urandom_range(0, 3)));
         quiet_traffic <= ($urandom_range(0, 2) == 0);
         phase_end = beats_sent + 100;
         while (beats_sent < phase_end) random_motion(steps);
      end

      req_if.valid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (sb.awaited.size() != 0 && waited < 20000);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
